// ===== rtl/r2y_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// r2y_pkg: shared types and constants of the RGB to YCbCr 4:2:0 converter
// BT.601 studio-range coefficients in Q16, payload structs, line geometry.
// ---------------------------------------------------------------------------
package r2y_pkg;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned LineDepth  = MaxWidth / 2;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned SlotW      = $clog2(LineDepth);
  localparam int unsigned FwW        = 13;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned CoefW      = 16;
  localparam int unsigned ProdW      = 8 + CoefW;
  localparam int unsigned AccW       = ProdW + 2;
  localparam int unsigned PairW      = 9;
  localparam int unsigned LineW      = 2 * PairW;

  localparam logic [FwW-1:0] FwReset    = FwW'(640);
  localparam logic [FwW-1:0] FwMax      = FwW'(MaxWidth);
  localparam logic           RegFwWidth = 1'b0;

  // round(c * 2^16)
  localparam logic [CoefW-1:0] CyR  = CoefW'(16829);
  localparam logic [CoefW-1:0] CyG  = CoefW'(33039);
  localparam logic [CoefW-1:0] CyB  = CoefW'(6416);
  localparam logic [CoefW-1:0] CcbR = CoefW'(9714);
  localparam logic [CoefW-1:0] CcbG = CoefW'(19071);
  localparam logic [CoefW-1:0] CcbB = CoefW'(28784);
  localparam logic [CoefW-1:0] CcrR = CoefW'(28784);
  localparam logic [CoefW-1:0] CcrG = CoefW'(24103);
  localparam logic [CoefW-1:0] CcrB = CoefW'(4681);

  localparam logic signed [AccW-1:0] YOfs = AccW'(16 << FracBits);
  localparam logic signed [AccW-1:0] COfs = AccW'(128 << FracBits);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb_avg;
    logic [7:0] cr_avg;
  } pixel_out_t;

endpackage

// ===== rtl/r2y_csc.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// r2y_csc: RGB to Y/Cb/Cr color matrix
// Three-stage pipeline: input register, constant products, offset sum with
// clamp and truncation to 8 bits. All stages advance together on en_i.
// ---------------------------------------------------------------------------
module r2y_csc (
  input  logic          clk_i,
  input  logic          en_i,
  input  r2y_pkg::rgb_t rgb_i,
  output logic [7:0]    luma_o,
  output logic [7:0]    cb_o,
  output logic [7:0]    cr_o
);

  localparam int unsigned PW = r2y_pkg::ProdW;
  localparam int unsigned AW = r2y_pkg::AccW;
  localparam int unsigned FB = r2y_pkg::FracBits;

  r2y_pkg::rgb_t rgb_q;
  logic [PW-1:0] yr_q, yg_q, yb_q, br_q, bg_q, bb_q, rr_q, rg_q, rb_q;
  logic [7:0]    luma_q, cb_q, cr_q;

  logic signed [AW-1:0] y_acc, cb_acc, cr_acc;

  function automatic logic [7:0] clamp_byte(input logic signed [AW-1:0] acc);
    logic [AW-FB-1:0] whole;
    whole = acc[AW-1:FB];
    if (acc < 0) begin
      return 8'd0;
    end else if (whole > (AW-FB)'(255)) begin
      return 8'd255;
    end else begin
      return whole[7:0];
    end
  endfunction

  always_comb begin
    y_acc  = r2y_pkg::YOfs + $signed({2'b00, yr_q}) + $signed({2'b00, yg_q})
           + $signed({2'b00, yb_q});
    cb_acc = r2y_pkg::COfs - $signed({2'b00, br_q}) - $signed({2'b00, bg_q})
           + $signed({2'b00, bb_q});
    cr_acc = r2y_pkg::COfs + $signed({2'b00, rr_q}) - $signed({2'b00, rg_q})
           - $signed({2'b00, rb_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rgb_q  <= rgb_i;
      yr_q   <= PW'(rgb_q.red)   * PW'(r2y_pkg::CyR);
      yg_q   <= PW'(rgb_q.green) * PW'(r2y_pkg::CyG);
      yb_q   <= PW'(rgb_q.blue)  * PW'(r2y_pkg::CyB);
      br_q   <= PW'(rgb_q.red)   * PW'(r2y_pkg::CcbR);
      bg_q   <= PW'(rgb_q.green) * PW'(r2y_pkg::CcbG);
      bb_q   <= PW'(rgb_q.blue)  * PW'(r2y_pkg::CcbB);
      rr_q   <= PW'(rgb_q.red)   * PW'(r2y_pkg::CcrR);
      rg_q   <= PW'(rgb_q.green) * PW'(r2y_pkg::CcrG);
      rb_q   <= PW'(rgb_q.blue)  * PW'(r2y_pkg::CcrB);
      luma_q <= clamp_byte(y_acc);
      cb_q   <= clamp_byte(cb_acc);
      cr_q   <= clamp_byte(cr_acc);
    end
  end

  assign luma_o = luma_q;
  assign cb_o   = cb_q;
  assign cr_o   = cr_q;

endmodule

// ===== rtl/rgb_to_yuv420_converter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_to_yuv420_converter: BT.601 RGB to YCbCr with 2x2 chroma averaging
// Per-pixel luma; chroma of each 2x2 block on its odd-row, odd-column pixel.
// Even-row pair sums are kept in a single-port-write line store.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  in       | in_valid_i/in_ready_o | in_pixel_i  (red, green, blue, frame_start)
//  out      | out_valid_o/out_ready_i | out_pixel_o (luma, chroma_valid, cb, cr)
//  config   | psel/penable/pready  | paddr, pwdata, prdata (frame_width at 0x0)
//
// One pixel per clock unless stalled; stages: input, products, sums, output.
// The whole pipeline, including the line store read, advances as one unit;
// it holds only while the output register is full and not taken.
// Line store writes from the last stage are forwarded to in-flight reads.
// Reset clears position, pending pair and valids; no clearing pass.
// ---------------------------------------------------------------------------
module rgb_to_yuv420_converter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  r2y_pkg::pixel_in_t     in_pixel_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output r2y_pkg::pixel_out_t    out_pixel_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned CW = r2y_pkg::ColW;
  localparam int unsigned SW = r2y_pkg::SlotW;
  localparam int unsigned WW = r2y_pkg::FwW;
  localparam int unsigned PW = r2y_pkg::PairW;
  localparam int unsigned LW = r2y_pkg::LineW;

  logic          adv;
  logic          accept;

  // configuration
  logic [WW-1:0] fw_q;
  logic          cfg_wr;

  // position
  logic [CW-1:0] col_q, col_d, col_cur;
  logic          odd_q, odd_d, odd_cur;
  logic [WW-1:0] width;
  logic [WW-1:0] col_inc;
  logic          wrap;

  // pipeline control
  logic          v1_q, v2_q, v3_q;
  logic          oc1_q, oc2_q, oc3_q;
  logic          or1_q, or2_q, or3_q;
  logic [SW-1:0] slot1_q, slot2_q, slot3_q;

  // line store
  logic [LW-1:0] line_mem [r2y_pkg::LineDepth];
  logic [LW-1:0] rd_q;
  logic          fwd_q;
  logic [LW-1:0] fwd_data_q;
  logic [LW-1:0] line1, line2_q, line3_q;
  logic          wr;
  logic [LW-1:0] wdata;

  // color matrix
  r2y_pkg::rgb_t in_rgb;
  logic [7:0]    y3, cb3, cr3;

  // chroma
  logic [15:0]   pend_q, pend_d;
  logic [PW-1:0] cb_pair, cr_pair;
  logic [PW:0]   cb_sum, cr_sum;
  logic          cv3;
  logic [7:0]    cb_avg3, cr_avg3;

  r2y_pkg::pixel_out_t out_q;
  logic                out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == r2y_pkg::RegFwWidth);
  assign prdata = (paddr[2] == r2y_pkg::RegFwWidth) ? {{(32-WW){1'b0}}, fw_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= r2y_pkg::FwReset;
    end else if (cfg_wr) begin
      fw_q <= pwdata[WW-1:0];
    end
  end

  // position tracking at the input
  always_comb begin
    col_cur = in_pixel_i.frame_start ? '0 : col_q;
    odd_cur = in_pixel_i.frame_start ? 1'b0 : odd_q;
    width   = (fw_q > r2y_pkg::FwMax) ? r2y_pkg::FwMax : fw_q;
    col_inc = {1'b0, col_cur} + WW'(1);
    wrap    = col_inc >= width;
    col_d   = wrap ? '0 : col_inc[CW-1:0];
    odd_d   = odd_cur ^ wrap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      odd_q <= 1'b0;
    end else if (accept) begin
      col_q <= col_d;
      odd_q <= odd_d;
    end
  end

  // pipeline control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else if (adv) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      fwd_q <= wr && (slot3_q == col_cur[CW-1:1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oc1_q      <= col_cur[0];
      or1_q      <= odd_cur;
      slot1_q    <= col_cur[CW-1:1];
      oc2_q      <= oc1_q;
      or2_q      <= or1_q;
      slot2_q    <= slot1_q;
      oc3_q      <= oc2_q;
      or3_q      <= or2_q;
      slot3_q    <= slot2_q;
      fwd_data_q <= wdata;
      // pick up writes that land after this item's read
      line2_q    <= (wr && (slot3_q == slot1_q)) ? wdata : line1;
      line3_q    <= (wr && (slot3_q == slot2_q)) ? wdata : line2_q;
    end
  end

  assign line1 = fwd_q ? fwd_data_q : rd_q;

  // line store
  always_ff @(posedge clk_i) begin
    if (wr) begin
      line_mem[slot3_q] <= wdata;
    end
    if (adv) begin
      rd_q <= line_mem[col_cur[CW-1:1]];
    end
  end

  assign in_rgb.red   = in_pixel_i.red;
  assign in_rgb.green = in_pixel_i.green;
  assign in_rgb.blue  = in_pixel_i.blue;

  r2y_csc u_csc (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rgb_i  (in_rgb),
    .luma_o (y3),
    .cb_o   (cb3),
    .cr_o   (cr3)
  );

  // chroma pairing and block average
  always_comb begin
    cb_pair = {1'b0, pend_q[7:0]}  + {1'b0, cb3};
    cr_pair = {1'b0, pend_q[15:8]} + {1'b0, cr3};
    wdata   = {cr_pair, cb_pair};
    wr      = adv && v3_q && oc3_q && !or3_q;
    cb_sum  = {1'b0, line3_q[PW-1:0]}  + {1'b0, cb_pair};
    cr_sum  = {1'b0, line3_q[LW-1:PW]} + {1'b0, cr_pair};
    cv3     = oc3_q && or3_q;
    cb_avg3 = cv3 ? cb_sum[PW:2] : 8'd0;
    cr_avg3 = cv3 ? cr_sum[PW:2] : 8'd0;
    pend_d  = (v3_q && !oc3_q) ? {cr3, cb3} : pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      pend_q      <= pend_d;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.luma         <= y3;
      out_q.chroma_valid <= cv3;
      out_q.cb_avg       <= cb_avg3;
      out_q.cr_avg       <= cr_avg3;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_q;

endmodule

// ===== tb/sv/rgb_to_yuv420_converter_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_to_yuv420_converter_tb: self-checking bench for the RGB to 4:2:0 converter
// A short table of hand-picked pixels runs first, some with hand-typed results.
// Random frames follow at many row widths, with random stalls on both sides.
// Every result is checked by field against its typed value or a Q16 BT.601 model here.
// ---------------------------------------------------------------------------
module rgb_to_yuv420_converter_tb;

  localparam int          LongHold = 300;
  localparam logic [2:0]  FwAddr   = 3'(4 * r2y_pkg::RegFwWidth);

  typedef struct packed {
    logic                set_width;
    logic [12:0]         width;
    r2y_pkg::pixel_in_t  px;
    logic                typed;
    r2y_pkg::pixel_out_t res;
  } directed_row_t;

  function automatic longint to_q16(input longint micro);
    return ((micro << r2y_pkg::FracBits) + 64'd500000) / 64'd1000000;
  endfunction

  localparam longint KyR  = to_q16(256788);
  localparam longint KyG  = to_q16(504129);
  localparam longint KyB  = to_q16(97906);
  localparam longint KcbR = to_q16(148223);
  localparam longint KcbG = to_q16(290993);
  localparam longint KcbB = to_q16(439216);
  localparam longint KcrR = to_q16(439216);
  localparam longint KcrG = to_q16(367788);
  localparam longint KcrB = to_q16(71427);

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  r2y_pkg::pixel_in_t  in_pixel_i;
  logic                out_valid_o;
  logic                out_ready_i;
  r2y_pkg::pixel_out_t out_pixel_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  rgb_to_yuv420_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // converter model state
  logic [12:0] width_reg;
  int unsigned pos_col;
  logic        pos_odd_row;
  logic [7:0]  held_cb;
  logic [7:0]  held_cr;
  logic [8:0]  pair_cb [r2y_pkg::LineDepth];
  logic [8:0]  pair_cr [r2y_pkg::LineDepth];

  r2y_pkg::pixel_out_t expected_pixels [$];
  directed_row_t       directed_rows [$];

  int  mismatches;
  int  pixels_sent;
  int  results_seen;
  int  chroma_blocks;
  int  widths_used;
  bit  src_idle_en;
  bit  sink_idle_en;
  bit  hold_request;

  always #4 clk_i = ~clk_i;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                              results_seen, field, got, want));
  endtask

  function automatic logic [7:0] clamp_q16(input longint acc);
    longint v;
    if (acc < 0) return 8'd0;
    v = acc >>> r2y_pkg::FracBits;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  // One pixel through the model; advances position and line store.
  function automatic r2y_pkg::pixel_out_t convert_pixel(input r2y_pkg::pixel_in_t px);
    longint              r, g, b;
    logic [7:0]          cb, cr;
    logic [8:0]          cb_pair, cr_pair;
    int unsigned         slot, row_len;
    r2y_pkg::pixel_out_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    res = '0;
    if (px.frame_start) begin
      pos_col = 0;
      pos_odd_row = 1'b0;
    end
    res.luma = clamp_q16((longint'(16) <<< r2y_pkg::FracBits) + r * KyR + g * KyG + b * KyB);
    cb = clamp_q16((longint'(128) <<< r2y_pkg::FracBits) - r * KcbR - g * KcbG + b * KcbB);
    cr = clamp_q16((longint'(128) <<< r2y_pkg::FracBits) + r * KcrR - g * KcrG - b * KcrB);
    if (!pos_col[0]) begin
      held_cb = cb;
      held_cr = cr;
    end else begin
      cb_pair = {1'b0, held_cb} + {1'b0, cb};
      cr_pair = {1'b0, held_cr} + {1'b0, cr};
      slot = pos_col >> 1;
      if (!pos_odd_row) begin
        pair_cb[slot] = cb_pair;
        pair_cr[slot] = cr_pair;
      end else begin
        res.chroma_valid = 1'b1;
        res.cb_avg = 8'((int'(pair_cb[slot]) + int'(cb_pair)) >> 2);
        res.cr_avg = 8'((int'(pair_cr[slot]) + int'(cr_pair)) >> 2);
      end
    end
    row_len = (width_reg > r2y_pkg::MaxWidth) ? r2y_pkg::MaxWidth : width_reg;
    pos_col++;
    if (pos_col >= row_len) begin
      pos_col = 0;
      pos_odd_row = ~pos_odd_row;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_level();
    if ($urandom_range(0, 99) < 15) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic directed_row_t plan_pixel(input bit set_w, input int w, input int r,
                                               input int g, input int b, input bit fs,
                                               input bit typed, input int y, input bit cv,
                                               input int cb, input int cr);
    directed_row_t row;
    row.set_width          = set_w;
    row.width              = 13'(w);
    row.px.red             = 8'(r);
    row.px.green           = 8'(g);
    row.px.blue            = 8'(b);
    row.px.frame_start     = fs;
    row.typed              = typed;
    row.res.luma           = 8'(y);
    row.res.chroma_valid   = cv;
    row.res.cb_avg         = 8'(cb);
    row.res.cr_avg         = 8'(cr);
    return row;
  endfunction

  // Called right after an edge or at a falling edge; returns after acceptance.
  task automatic send_pixel(input r2y_pkg::pixel_in_t px, input bit typed,
                            input r2y_pkg::pixel_out_t typed_res);
    int                  gap;
    r2y_pkg::pixel_out_t predicted;
    gap = src_idle_en ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = convert_pixel(px);
    expected_pixels.push_back(typed ? typed_res : predicted);
    pixels_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
  endtask

  // Idle-only register update, followed by a read-back.
  task automatic program_width(input logic [12:0] w);
    wait_results_drained();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FwAddr;
    pwdata  <= {19'b0, w};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    width_reg = w;
    widths_used++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {19'b0, w})
      flag_mismatch($sformatf("frame_width read back %0d, wrote %0d", prdata, w));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [12:0] w, input int budget, input bit hold_mid,
                           input bit drain_mid);
    int                  row_len, frame_len, k, sent;
    r2y_pkg::pixel_in_t  px;
    r2y_pkg::pixel_out_t none;
    none = '0;
    program_width(w);
    src_idle_en  = ($urandom_range(0, 9) < 7);
    sink_idle_en = ($urandom_range(0, 9) < 7);
    row_len = (w > r2y_pkg::MaxWidth) ? r2y_pkg::MaxWidth : ((w < 2) ? 1 : int'(w));
    sent = 0;
    while (sent < budget) begin
      frame_len = row_len * $urandom_range(1, 5);
      // now and then a frame is cut short in mid-row
      if ($urandom_range(0, 9) == 0) frame_len = $urandom_range(1, frame_len);
      for (k = 0; k < frame_len && sent < budget; k++) begin
        px.red         = rand_level();
        px.green       = rand_level();
        px.blue        = rand_level();
        px.frame_start = (k == 0) || ($urandom_range(0, 99) < 2);
        if (sent == budget / 2) begin
          if (hold_mid) hold_request = 1'b1;
          if (drain_mid) wait_results_drained();
        end
        send_pixel(px, 1'b0, none);
        sent++;
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    r2y_pkg::pixel_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        flag_mismatch("result arrived with nothing expected");
      end else begin
        want = expected_pixels.pop_front();
        check_field("luma", out_pixel_o.luma, want.luma);
        check_field("chroma_valid", {7'b0, out_pixel_o.chroma_valid}, {7'b0, want.chroma_valid});
        check_field("cb_avg", out_pixel_o.cb_avg, want.cb_avg);
        check_field("cr_avg", out_pixel_o.cr_avg, want.cr_avg);
        if (want.chroma_valid) chroma_blocks++;
      end
      results_seen++;
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LongHold;
      end else if (stall_left == 0 && sink_idle_en) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : run_limit
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int         small_items, budget, p, wait_cycles;
    logic [12:0] w;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_pixel_i   = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    hold_request = 1'b0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    mismatches   = 0;
    pixels_sent  = 0;
    results_seen = 0;
    chroma_blocks = 0;
    widths_used  = 0;
    width_reg    = r2y_pkg::FwReset;
    pos_col      = 0;
    pos_odd_row  = 1'b0;
    held_cb      = '0;
    held_cr      = '0;

    //                              set w     r    g    b  fs typ   y cv  cb   cr
    directed_rows.push_back(plan_pixel(0,    0,   0,   0,   0, 1, 1,  16, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0, 255, 255, 255, 0, 1, 235, 0,   0,   0));
    // two-pixel rows: one 2x2 block of black
    directed_rows.push_back(plan_pixel(1,    2,   0,   0,   0, 1, 1,  16, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,   0,   0,   0, 0, 1,  16, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,   0,   0,   0, 0, 1,  16, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,   0,   0,   0, 0, 1,  16, 1, 128, 128));
    directed_rows.push_back(plan_pixel(0,    0, 255,   0,   0, 1, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,   0, 255,   0, 0, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,   0,   0, 255, 0, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0, 255, 255, 255, 0, 0,   0, 0,   0,   0));
    // odd width: last column, then an odd last row
    directed_rows.push_back(plan_pixel(1,    3, 200,  10,  90, 1, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,  10, 200,  30, 0, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0, 255, 128,   0, 0, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,   1,   2,   3, 0, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0, 128, 128, 128, 0, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,  77,  33, 250, 0, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,   5, 250,   5, 0, 0,   0, 0,   0,   0));
    // degenerate widths: every pixel ends a row
    directed_rows.push_back(plan_pixel(1,    0, 255,   0, 255, 1, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,   0, 255,   0, 0, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0, 128,  64,  32, 0, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(1,    1,   0, 255, 255, 1, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0, 255, 255,   0, 0, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,   9,  99, 199, 0, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(1, 4096, 255, 255, 255, 1, 0,   0, 0,   0,   0));
    directed_rows.push_back(plan_pixel(0,    0,   0,   0,   0, 0, 0,   0, 0,   0,   0));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_width) program_width(directed_rows[i].width);
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].res);
    end

    run_phase(13'd2, 40, 1'b0, 1'b0);
    run_phase(13'($urandom_range(4, 12)), 60, 1'b1, 1'b0);
    run_phase(13'($urandom_range(4, 12)), 60, 1'b0, 1'b1);
    // width register above the line store size; row length saturates
    run_phase(13'h1FFF, 40, 1'b0, 1'b0);

    small_items = 200;
    while (small_items < 520) begin
      p = $urandom_range(0, 99);
      if (p < 10) w = 13'd2;
      else if (p < 20) w = 13'd3;
      else if (p < 80) w = 13'($urandom_range(4, 24));
      else w = 13'($urandom_range(25, 200));
      budget = $urandom_range(20, 70);
      run_phase(w, budget, $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
      small_items += budget;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (expected_pixels.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (expected_pixels.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
    repeat (10) @(posedge clk_i);

    $display("Sent %0d pixels over %0d width settings; %0d results checked, %0d with chroma.",
             pixels_sent, widths_used, results_seen, chroma_blocks);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/r2y_pkg.sv
rtl/r2y_csc.sv
rtl/rgb_to_yuv420_converter.sv
tb/sv/rgb_to_yuv420_converter_tb.sv
